>>> hdl/rgbh_pkg.sv
`default_nettype none
package rgbh_pkg;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned NUM_BINS = 256;
  localparam int unsigned BIN_BITS = 8;
  localparam int unsigned OUT_COUNT_BITS = 24;
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned LEVEL_FRAC = 15;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
endpackage
`default_nettype wire

>>> hdl/rgbh_ram.sv
`default_nettype none
module rgbh_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/rgbh_lane.sv
`default_nettype none
// One channel: bin memory, read port, saturating increment and clear.
module rgbh_lane
  import rgbh_pkg::*;
#(
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_i,
  input  wire logic [BIN_BITS-1:0]  raddr_i,
  input  wire logic                 inc_i,
  input  wire logic                 clr_i,
  input  wire logic [BIN_BITS-1:0]  waddr_i,
  output      logic [CountBits-1:0] rdata_o,
  output      logic [CountBits-1:0] wdata_o
);
  logic                 we;
  logic [CountBits-1:0] wdata;

  always_comb begin
    wdata = '0;
    if (!clr_i && rdata_o != {CountBits{1'b1}}) begin
      wdata = rdata_o + CountBits'(1);
    end else if (!clr_i) begin
      wdata = rdata_o;
    end
  end
  assign we = inc_i || clr_i;
  assign wdata_o = wdata;

  rgbh_ram #(.Width(CountBits), .Depth(NUM_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_i),
    .wdata_i (wdata),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );
  logic unused;
  assign unused = rd_i;
endmodule
`default_nettype wire

>>> hdl/rgbh_div.sv
`default_nettype none
// Restoring divider: level = floor(count * 2^15 / peak), one quotient bit a cycle.
module rgbh_div
  import rgbh_pkg::*;
#(
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [CountBits-1:0]  count_i,
  input  wire logic [CountBits-1:0]  peak_i,
  output      logic                  done_o,
  output      logic [LEVEL_BITS-1:0] level_o
);
  localparam int unsigned StepBits = $clog2(LEVEL_FRAC + 2);
  logic [CountBits:0]    rem_q, rem_d;
  logic [CountBits-1:0]  peak_q;
  logic [LEVEL_BITS-1:0] quo_q;
  logic [StepBits-1:0]   step_q;
  logic                  run_q;
  logic [CountBits:0]    trial;

  // count <= peak, so the first quotient bit is the 2^15 position
  always_comb begin
    trial = rem_q - {1'b0, peak_q};
    rem_d = rem_q;
    if (!trial[CountBits]) begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepBits'(1);
        if (step_q == StepBits'(LEVEL_FRAC)) begin
          run_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, count_i};
      peak_q <= peak_i;
      quo_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[LEVEL_BITS-2:0], ~trial[CountBits]};
      rem_q <= {rem_d[CountBits-1:0], 1'b0};
    end
  end
  assign level_o = quo_q;
endmodule
`default_nettype wire

>>> hdl/rgb_histogram_normalized_top.sv
`default_nettype none
// Channel   | Dir | Handshake          | Payload
// request   | in  | start, busy        | command, blue/green/red value, bin_index
// result    | out | result_valid_o     | counts, peak, levels
// An add reads the bins, then increments them and merges the maximum, then updates the peak;
// three lanes work in parallel. A read does the memory read, loads the dividers, runs the 16 steps of
// the per-lane bit-serial dividers, then gives the result.
// A clear sweeps 256 bins, one a cycle, all lanes at once.
// After reset the same clearing sweep runs, with busy high.
// Results are shown for one cycle with result_valid_o; the receiver cannot stall.
module rgb_histogram_normalized_top
  import rgbh_pkg::*;
#(
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [1:0]                command_i,
  input  wire logic [7:0]                blue_value_i,
  input  wire logic [7:0]                green_value_i,
  input  wire logic [7:0]                red_value_i,
  input  wire logic [7:0]                bin_index_i,
  output      logic                      result_valid_o,
  output      logic [OUT_COUNT_BITS-1:0] blue_count_o,
  output      logic [OUT_COUNT_BITS-1:0] green_count_o,
  output      logic [OUT_COUNT_BITS-1:0] red_count_o,
  output      logic [OUT_COUNT_BITS-1:0] peak_count_o,
  output      logic [LEVEL_BITS-1:0]     blue_level_o,
  output      logic [LEVEL_BITS-1:0]     green_level_o,
  output      logic [LEVEL_BITS-1:0]     red_level_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_PEAK = 3'd5;

  logic [2:0]           state_q;
  logic [BIN_BITS-1:0]  addr_q [3];
  logic [BIN_BITS-1:0]  clr_q;
  logic [CountBits-1:0] peak_q;
  logic [CountBits-1:0] rdata [3];
  logic [CountBits-1:0] wdata [3];
  logic [CountBits-1:0] mx_q;
  logic                 accept;
  logic                 div_start;
  logic [2:0]           div_done;
  logic [LEVEL_BITS-1:0] level [3];
  logic [BIN_BITS-1:0]  raddr [3];
  logic [BIN_BITS-1:0]  waddr;

  assign accept = start && !busy;
  assign busy = (state_q != ST_IDLE);

  always_comb begin
    raddr[0] = blue_value_i;
    raddr[1] = green_value_i;
    raddr[2] = red_value_i;
    if (command_i == CMD_READ) begin
      raddr[0] = bin_index_i;
      raddr[1] = bin_index_i;
      raddr[2] = bin_index_i;
    end
  end
  assign waddr = clr_q;
  assign div_start = (state_q == ST_RD);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rgbh_lane #(.CountBits(CountBits)) u_lane (
      .clk_i   (clk_i),
      .rd_i    (accept),
      .raddr_i (raddr[l]),
      .inc_i   (state_q == ST_ADD),
      .clr_i   (state_q == ST_CLR),
      .waddr_i ((state_q == ST_CLR) ? waddr : addr_q[l]),
      .rdata_o (rdata[l]),
      .wdata_o (wdata[l])
    );
    rgbh_div #(.CountBits(CountBits)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .count_i (rdata[l]),
      .peak_i  (peak_q),
      .done_o  (div_done[l]),
      .level_o (level[l])
    );
  end

  // merge: largest of the three new counts, registered before the peak compare
  logic [CountBits-1:0] mx01;
  assign mx01 = (wdata[0] > wdata[1]) ? wdata[0] : wdata[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
      peak_q <= CountBits'(1);
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_ADD:   state_q <= ST_ADD;
              CMD_CLEAR: begin
                state_q <= ST_CLR;
                clr_q <= '0;
              end
              CMD_READ:  state_q <= ST_RD;
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ADD: state_q <= ST_PEAK;
        ST_PEAK: begin
          if (mx_q > peak_q) begin
            peak_q <= mx_q;
          end
          state_q <= ST_IDLE;
        end
        ST_CLR: begin
          clr_q <= clr_q + BIN_BITS'(1);
          peak_q <= CountBits'(1);
          if (clr_q == BIN_BITS'(NUM_BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done[0]) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q[0] <= blue_value_i;
      addr_q[1] <= green_value_i;
      addr_q[2] <= red_value_i;
    end
    if (state_q == ST_ADD) begin
      mx_q <= (mx01 > wdata[2]) ? mx01 : wdata[2];
    end
    if (state_q == ST_RD) begin
      blue_count_o  <= OUT_COUNT_BITS'(rdata[0]);
      green_count_o <= OUT_COUNT_BITS'(rdata[1]);
      red_count_o   <= OUT_COUNT_BITS'(rdata[2]);
      peak_count_o  <= OUT_COUNT_BITS'(peak_q);
    end
  end

  assign result_valid_o = div_done[0];
  assign blue_level_o  = level[0];
  assign green_level_o = level[1];
  assign red_level_o   = level[2];

  logic unused;
  assign unused = ^div_done[2:1];
endmodule
`default_nettype wire
